// ----- rtl/str_pkg.sv -----
// shared types and constants for the timer, rtc, interrupt and uart register block
package str_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_RTC_PRESCALE  = 2'd0,
		CFG_OS_PRESCALE   = 2'd1,
		CFG_UART_PRESCALE = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] addr;
		logic [31:0] wdata;
		logic        rx_valid;
		logic [7:0]  rx_byte;
	} req_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic        irq;
		logic        fiq;
		logic        watchdog_reset;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        rx_taken;
	} rsp_t;

	localparam logic [31:0] A_ICIP = 32'h40D00000;
	localparam logic [31:0] A_ICMR = 32'h40D00004;
	localparam logic [31:0] A_ICLR = 32'h40D00008;
	localparam logic [31:0] A_ICFP = 32'h40D0000C;
	localparam logic [31:0] A_ICPR = 32'h40D00010;
	localparam logic [31:0] A_RCNR = 32'h40900000;
	localparam logic [31:0] A_RTAR = 32'h40900004;
	localparam logic [31:0] A_RTSR = 32'h40900008;
	localparam logic [31:0] A_RTTR = 32'h4090000C;
	localparam logic [31:0] A_OSMR0 = 32'h40A00000;
	localparam logic [31:0] A_OSMR1 = 32'h40A00004;
	localparam logic [31:0] A_OSMR2 = 32'h40A00008;
	localparam logic [31:0] A_OSMR3 = 32'h40A0000C;
	localparam logic [31:0] A_OSCR = 32'h40A00010;
	localparam logic [31:0] A_OSSR = 32'h40A00014;
	localparam logic [31:0] A_OWER = 32'h40A00018;
	localparam logic [31:0] A_OIER = 32'h40A0001C;
	localparam logic [31:0] A_URBR = 32'h40100000;
	localparam logic [31:0] A_UIER = 32'h40100004;
	localparam logic [31:0] A_UIIR = 32'h40100008;
	localparam logic [31:0] A_ULCR = 32'h4010000C;
	localparam logic [31:0] A_ULSR = 32'h40100014;
	localparam logic [31:0] A_CCCR = 32'h41300000;
	localparam logic [31:0] A_CKEN = 32'h41300004;
	localparam logic [31:0] A_OSCC = 32'h41300008;

	localparam int          BIT_ALARM = 31;
	localparam int          BIT_HZ    = 30;
	localparam int          BIT_UART  = 22;
	localparam int          OS_SHIFT  = 26;

	localparam logic [16:0] CKEN_MASK  = 17'h17DEF;
	localparam logic [9:0]  CCCR_RESET = 10'h121;
	localparam logic [7:0]  FCR_MASK   = 8'hC7;
	localparam logic [7:0]  IIR_MASK   = 8'hCF;
	localparam logic [7:0]  LSR_THRE   = 8'h60;

	localparam logic [15:0] RTC_PRESCALE_RESET  = 16'd64;
	localparam logic [15:0] OS_PRESCALE_RESET   = 16'd0;
	localparam logic [15:0] UART_PRESCALE_RESET = 16'd200;

endpackage

// ----- rtl/soc_timer_rtc_irq_uart_regs.sv -----
// top level: rtc, os timer, uart stub and interrupt controller register block
// an accepted request's result is registered into the output register, or the skid if stalled
// throughput: one request per cycle while the skid is empty; a result register with a skid
//   stage lets the next request in while a result waits
// every tick, read and write is finished by one pass of logic into the state registers
// reset: asynchronous active-low arst_n clears all state but the result registers, sets clock config to 0x121,
//   clock enable to 0x17def, prescales to 64, 0 and 200
module soc_timer_rtc_irq_uart_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  str_pkg::req_t      in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output str_pkg::rsp_t      out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata
);

	// configuration registers
	logic [15:0] rtc_pre_q, os_pre_q, uart_pre_q;

	// architectural state
	logic [31:0] pend_q, mask_q, level_q;
	logic        irq_q, fiq_q;
	logic [31:0] rtc_count_q, rtc_alarm_q, rtc_div_q;
	logic [3:0]  rtc_status_q;
	logic [25:0] rtc_trim_q;
	logic [31:0] os_count_q;
	logic [31:0] os_match_q [4];
	logic        wde_q;
	logic [3:0]  os_status_q, os_ie_q;
	logic [7:0]  rbr_q, uier_q, uiir_q, fcr_q, lcr_q, lsr_q;
	logic [9:0]  cccr_q;
	logic [16:0] cken_q;
	logic [1:0]  oscc_q;

	// output register plus skid
	logic          out_valid_q, skid_valid_q;
	str_pkg::rsp_t out_q, skid_q;

	logic accept;
	assign in_ready  = !skid_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic is_tick, is_rd, is_wr;
	assign is_tick = accept && (in_data.cmd == str_pkg::CMD_TICK);
	assign is_rd   = accept && (in_data.cmd == str_pkg::CMD_READ);
	assign is_wr   = accept && (in_data.cmd == str_pkg::CMD_WRITE);

	logic rtc_hit, os_hit, uart_hit;

	str_prescale u_rtc_pre (.clk, .arst_n, .tick(is_tick), .limit(rtc_pre_q), .hit(rtc_hit));
	str_prescale u_os_pre (.clk, .arst_n, .tick(is_tick), .limit(os_pre_q), .hit(os_hit));
	str_prescale u_uart_pre (.clk, .arst_n, .tick(is_tick), .limit(uart_pre_q), .hit(uart_hit));

	// next-state values
	logic [31:0] pend_d, mask_d, level_d, rtc_count_d, rtc_alarm_d, rtc_div_d, os_count_d;
	logic [31:0] os_match_d [4];
	logic        irq_d, fiq_d, wde_d;
	logic [3:0]  rtc_status_d, os_status_d, os_ie_d, hits;
	logic [25:0] rtc_trim_d;
	logic [7:0]  rbr_d, uier_d, uiir_d, fcr_d, lcr_d, lsr_d;
	logic [9:0]  cccr_d;
	logic [16:0] cken_d;
	logic [1:0]  oscc_d;
	str_pkg::rsp_t rsp;
	logic [31:0] a, d;

	always_comb begin
		pend_d = pend_q; mask_d = mask_q; level_d = level_q;
		irq_d = irq_q; fiq_d = fiq_q;
		rtc_count_d = rtc_count_q; rtc_alarm_d = rtc_alarm_q; rtc_div_d = rtc_div_q;
		rtc_status_d = rtc_status_q; rtc_trim_d = rtc_trim_q;
		os_count_d = os_count_q;
		for (int i = 0; i < 4; i++) os_match_d[i] = os_match_q[i];
		wde_d = wde_q; os_status_d = os_status_q; os_ie_d = os_ie_q;
		rbr_d = rbr_q; uier_d = uier_q; uiir_d = uiir_q; fcr_d = fcr_q;
		lcr_d = lcr_q; lsr_d = lsr_q;
		cccr_d = cccr_q; cken_d = cken_q; oscc_d = oscc_q;
		hits = '0;
		a = in_data.addr;
		d = in_data.wdata;
		rsp = '0;

		if (is_tick) begin
			// rtc trim divider
			if (rtc_hit) begin
				rtc_div_d = rtc_div_q + 32'd1;
				if (rtc_div_q == {16'd0, rtc_trim_q[15:0]}) begin
					rtc_div_d = '0;
					rtc_count_d = rtc_count_q + 32'd1;
					if ((rtc_count_q == rtc_alarm_q) && rtc_status_q[2])
						rtc_status_d[0] = 1'b1;
					if (rtc_status_q[3])
						rtc_status_d[1] = 1'b1;
				end
				if (rtc_status_d[0] && rtc_status_d[2]) pend_d[str_pkg::BIT_ALARM] = 1'b1;
				if (rtc_status_d[1] && rtc_status_d[3]) pend_d[str_pkg::BIT_HZ] = 1'b1;
			end
			// os timer matches
			if (os_hit) begin
				os_count_d = os_count_q + 32'd1;
				for (int i = 0; i < 4; i++) hits[i] = (os_count_q == os_match_q[i]);
				rsp.watchdog_reset = hits[3] && wde_q;
				os_status_d = os_status_q | hits;
				pend_d[str_pkg::OS_SHIFT +: 4] = pend_d[str_pkg::OS_SHIFT +: 4]
					| (os_ie_q & os_status_d);
			end
			// uart receive poll
			if (uart_hit && !pend_d[str_pkg::BIT_UART]) begin
				if (in_data.rx_valid) begin
					rbr_d = in_data.rx_byte;
					uiir_d[2] = 1'b1;
					lsr_d[0] = 1'b1;
					rsp.rx_taken = 1'b1;
				end
				if (uier_q[0] && uiir_d[2]) begin
					pend_d[str_pkg::BIT_UART] = 1'b1;
					uiir_d[0] = 1'b0;
				end
				if (uier_q[1]) begin
					pend_d[str_pkg::BIT_UART] = 1'b1;
					uiir_d[1] = 1'b1;
					uiir_d[0] = 1'b0;
					lsr_d = lsr_d | str_pkg::LSR_THRE;
				end
			end
			irq_d = |(mask_q & pend_d & ~level_q);
			fiq_d = |(mask_q & pend_d & level_q);
		end

		if (is_rd) begin
			case (a)
				str_pkg::A_RCNR:  rsp.rdata = rtc_count_q;
				str_pkg::A_RTAR:  rsp.rdata = rtc_alarm_q;
				str_pkg::A_RTSR:  rsp.rdata = {28'd0, rtc_status_q};
				str_pkg::A_RTTR:  rsp.rdata = {6'd0, rtc_trim_q};
				str_pkg::A_OSCR:  rsp.rdata = os_count_q;
				str_pkg::A_OSMR0: rsp.rdata = os_match_q[0];
				str_pkg::A_OSMR1: rsp.rdata = os_match_q[1];
				str_pkg::A_OSMR2: rsp.rdata = os_match_q[2];
				str_pkg::A_OSMR3: rsp.rdata = os_match_q[3];
				str_pkg::A_OWER:  rsp.rdata = {31'd0, wde_q};
				str_pkg::A_OSSR:  rsp.rdata = {28'd0, os_status_q};
				str_pkg::A_OIER:  rsp.rdata = {28'd0, os_ie_q};
				str_pkg::A_ICPR:  rsp.rdata = pend_q;
				str_pkg::A_ICIP:  rsp.rdata = mask_q & pend_q & ~level_q;
				str_pkg::A_ICFP:  rsp.rdata = mask_q & pend_q & level_q;
				str_pkg::A_ICMR:  rsp.rdata = mask_q;
				str_pkg::A_ICLR:  rsp.rdata = level_q;
				str_pkg::A_URBR: begin
					pend_d[str_pkg::BIT_UART] = 1'b0;
					uiir_d[2] = 1'b0;
					uiir_d[0] = 1'b1;
					lsr_d[0] = 1'b0;
					rsp.rdata = {24'd0, rbr_q};
				end
				str_pkg::A_UIER:  rsp.rdata = {24'd0, uier_q};
				str_pkg::A_UIIR: begin
					pend_d[str_pkg::BIT_UART] = 1'b0;
					rsp.rdata = {24'd0, uiir_q & str_pkg::IIR_MASK};
				end
				str_pkg::A_ULCR:  rsp.rdata = {24'd0, lcr_q};
				str_pkg::A_ULSR: begin
					lsr_d = lsr_q | str_pkg::LSR_THRE;
					rsp.rdata = {24'd0, lsr_d};
				end
				str_pkg::A_CCCR:  rsp.rdata = {22'd0, cccr_q};
				str_pkg::A_CKEN:  rsp.rdata = {15'd0, cken_q};
				str_pkg::A_OSCC:  rsp.rdata = {30'd0, oscc_q};
				default:          rsp.rdata = '0;
			endcase
		end

		if (is_wr) begin
			case (a)
				str_pkg::A_RCNR:  rtc_count_d = d;
				str_pkg::A_RTAR:  rtc_alarm_d = d;
				str_pkg::A_RTSR:  rtc_status_d = (rtc_status_q | (d[3:0] & 4'hC))
					& ~(d[3:0] & 4'h3);
				str_pkg::A_RTTR:  rtc_trim_d = d[25:0];
				str_pkg::A_OSCR:  os_count_d = d;
				str_pkg::A_OSMR0: os_match_d[0] = d;
				str_pkg::A_OSMR1: os_match_d[1] = d;
				str_pkg::A_OSMR2: os_match_d[2] = d;
				str_pkg::A_OSMR3: os_match_d[3] = d;
				str_pkg::A_OWER:  wde_d = wde_q | d[0];
				str_pkg::A_OSSR:  os_status_d = os_status_q & ~d[3:0];
				str_pkg::A_OIER:  os_ie_d = d[3:0];
				str_pkg::A_ICPR:  pend_d = d;
				str_pkg::A_ICMR: begin
					mask_d = d;
					pend_d = pend_q & ~d;
				end
				str_pkg::A_ICLR:  level_d = d;
				str_pkg::A_URBR: begin
					rsp.tx_valid = 1'b1;
					rsp.tx_byte = d[7:0];
					uiir_d[1] = 1'b0;
					uiir_d[0] = 1'b1;
					lsr_d = lsr_q & ~str_pkg::LSR_THRE;
				end
				str_pkg::A_UIER:  uier_d = d[7:0];
				str_pkg::A_UIIR:  fcr_d = d[7:0] & str_pkg::FCR_MASK;
				str_pkg::A_ULCR:  lcr_d = d[7:0];
				str_pkg::A_CCCR:  cccr_d = d[9:0];
				str_pkg::A_CKEN:  cken_d = d[16:0] & str_pkg::CKEN_MASK;
				str_pkg::A_OSCC:  oscc_d = d[1:0];
				default: ;
			endcase
		end

		rsp.irq = irq_d;
		rsp.fiq = fiq_d;
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0; mask_q <= '0; level_q <= '0;
			irq_q <= 1'b0; fiq_q <= 1'b0;
			rtc_count_q <= '0; rtc_alarm_q <= '0; rtc_div_q <= '0;
			rtc_status_q <= '0; rtc_trim_q <= '0;
			os_count_q <= '0;
			for (int i = 0; i < 4; i++) os_match_q[i] <= '0;
			wde_q <= 1'b0; os_status_q <= '0; os_ie_q <= '0;
			rbr_q <= '0; uier_q <= '0; uiir_q <= '0; fcr_q <= '0;
			lcr_q <= '0; lsr_q <= '0;
			cccr_q <= str_pkg::CCCR_RESET; cken_q <= str_pkg::CKEN_MASK; oscc_q <= '0;
		end else if (accept) begin
			pend_q <= pend_d; mask_q <= mask_d; level_q <= level_d;
			irq_q <= irq_d; fiq_q <= fiq_d;
			rtc_count_q <= rtc_count_d; rtc_alarm_q <= rtc_alarm_d; rtc_div_q <= rtc_div_d;
			rtc_status_q <= rtc_status_d; rtc_trim_q <= rtc_trim_d;
			os_count_q <= os_count_d;
			for (int i = 0; i < 4; i++) os_match_q[i] <= os_match_d[i];
			wde_q <= wde_d; os_status_q <= os_status_d; os_ie_q <= os_ie_d;
			rbr_q <= rbr_d; uier_q <= uier_d; uiir_q <= uiir_d; fcr_q <= fcr_d;
			lcr_q <= lcr_d; lsr_q <= lsr_d;
			cccr_q <= cccr_d; cken_q <= cken_d; oscc_q <= oscc_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtc_pre_q  <= str_pkg::RTC_PRESCALE_RESET;
			os_pre_q   <= str_pkg::OS_PRESCALE_RESET;
			uart_pre_q <= str_pkg::UART_PRESCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				str_pkg::CFG_RTC_PRESCALE:  rtc_pre_q <= cfg_wdata;
				str_pkg::CFG_OS_PRESCALE:   os_pre_q <= cfg_wdata;
				str_pkg::CFG_UART_PRESCALE: uart_pre_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// result register with skid: the skid only fills when the output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_ready) begin
				out_valid_q  <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : rsp;
		end
		if (accept && out_valid_q && !out_ready) begin
			skid_q <= rsp;
		end
	end

`ifndef ASSERT_OFF
	// no request taken while the skid holds a result
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !accept) else $error("accept with full skid");
	// skid implies a stalled output
	a_skid_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q) else $error("skid without output");
	// watchdog pulse only on a tick
	a_wd_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rsp.watchdog_reset) |-> is_tick) else $error("watchdog off tick");
	// irq and fiq lines only move on a tick
	a_irq_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_tick) |=> $stable(irq_q) && $stable(fiq_q))
		else $error("irq moved on bus access");
`endif

endmodule

// ----- rtl/str_prescale.sv -----
// prescale counter that fires once every limit ticks, or on every tick when limit is 0
module str_prescale (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  logic [15:0] limit,
	output logic        hit
);

	logic [15:0] count_q;
	logic [16:0] next;

	assign next = {1'b0, count_q} + 17'd1;
	assign hit  = tick && (next >= {1'b0, limit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (tick) begin
			count_q <= hit ? 16'd0 : next[15:0];
		end
	end

endmodule
